/* src/ssgd_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse SGD weight update package
// Types and constants shared by the sparse SGD weight store.
// ----------------------------------------------------------------------------
`default_nettype none

package ssgd_pkg;

	localparam int WEIGHT_COUNT = 4096;
	localparam int IDX_W        = $clog2(WEIGHT_COUNT);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_APPLY = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_PLAIN    = 2'd0,
		MODE_ADAGRAD  = 2'd1,
		MODE_MOMENTUM = 2'd2,
		MODE_RSVD     = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd2;

	localparam logic [31:0] RATE_RESET = 32'd655;
	localparam logic [16:0] BETA_RESET = 17'd58982;
	localparam logic [16:0] BETA_ONE   = 17'd65536;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [IDX_W-1:0]  weight_index;
		logic signed [31:0] data_value;
	} grad_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_index;
		logic signed [31:0] weight_out;
		logic               saturated;
	} res_word_t;

endpackage

`default_nettype wire

/* src/sparse_sgd_weight_update.sv */
// One shared 33x33 multiplier serves every mode; adagrad adds a 32-step root
//   and a 64-step divide.
// The input stalls until the result is registered, so one word is handled at a time.
// Reset: control and config registers reset at once (config to its defaults), then a
//   pass over all 4096 entries zeroes weight and history memories; no word is taken
//   during that pass.
// ----------------------------------------------------------------------------
// Sparse SGD weight update
// Weight store with plain, adagrad and shared-momentum update rules.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_sgd_weight_update (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              grad_valid,
	output logic                             grad_stall,
	input  ssgd_pkg::grad_word_t             grad,
	output logic                             res_valid,
	input  wire                              res_stall,
	output ssgd_pkg::res_word_t              res,
	input  wire                              cfg_we,
	input  wire [ssgd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ssgd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import ssgd_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RV, S_MODE, S_HIST, S_SQRT, S_DIV,
		S_CLO, S_CHI, S_CB, S_AVG, S_ADD, S_WB
	} state_t;

	state_t state_q;

	logic [1:0]  mode_q;
	logic [31:0] rate_q;
	logic [16:0] beta_q;

	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       cmd_q;
	logic signed [31:0] val_q;
	logic signed [31:0] avg_q;

	logic signed [31:0] w_rd_q;
	logic [47:0]        h_rd_q;
	logic signed [31:0] w_mem [WEIGHT_COUNT];
	logic [47:0]        h_mem [WEIGHT_COUNT];

	logic signed [63:0] prod_q;
	logic signed [63:0] rv_q;
	logic signed [47:0] r_q;
	logic [63:0]        lo_q;
	logic [64:0]        t2_q;
	logic [63:0]        op_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [63:0]        dvd_q;
	logic [63:0]        quo_q;
	logic [31:0]        rem_q;
	logic [5:0]         cnt_q;
	logic signed [48:0] delta_q;
	logic               flag_q;
	logic signed [31:0] wnew_q;
	logic [47:0]        hnew_q;
	logic               h_we_q;

	logic               accept;
	logic               out_free;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [16:0]        b_eff;
	logic [16:0]        c_eff;
	logic signed [47:0] r_now;
	logic [47:0]        m_abs;
	logic [46:0]        sq;
	logic [48:0]        h_sum;
	logic [47:0]        h_sat;
	logic [63:0]        sq_try;
	logic [31:0]        dsr;
	logic [32:0]        dv_try;
	logic [64:0]        t2_now;
	logic signed [64:0] avg_sum;
	logic signed [64:0] avg_rnd;
	logic signed [48:0] w_sum;
	logic [63:0]        quo_fin;
	logic [63:0]        q_clamp;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
		if (x > 49'sd2147483647)       return 32'sh7FFFFFFF;
		else if (x < -49'sd2147483648) return 32'sh80000000;
		else                           return x[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [48:0] x);
		return (x > 49'sd2147483647) || (x < -49'sd2147483648);
	endfunction

	assign accept     = grad_valid && !grad_stall;
	assign grad_stall = (state_q != S_IDLE);
	assign out_free   = !res_valid || !res_stall;

	assign b_eff = (beta_q > BETA_ONE) ? BETA_ONE : beta_q;
	assign c_eff = BETA_ONE - b_eff;
	assign r_now = 48'((prod_q + 64'sd32768) >>> 16);
	assign m_abs = r_q[47] ? 48'(-r_q) : 48'(r_q);

	always_comb begin
		case (state_q)
			S_RV: begin
				mul_a = {1'b0, rate_q};
				mul_b = {val_q[31], val_q};
			end
			S_MODE: begin
				mul_a = {val_q[31], val_q};
				mul_b = {val_q[31], val_q};
			end
			S_CLO: begin
				mul_a = {9'd0, m_abs[23:0]};
				mul_b = {16'd0, c_eff};
			end
			S_CHI: begin
				mul_a = {9'd0, m_abs[47:24]};
				mul_b = {16'd0, c_eff};
			end
			default: begin
				mul_a = {avg_q[31], avg_q};
				mul_b = {16'd0, b_eff};
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign sq     = 47'((64'(prod_q) + 64'd32768) >> 16);
	assign h_sum  = {1'b0, h_rd_q} + {2'b0, sq};
	assign h_sat  = h_sum[48] ? {48{1'b1}} : h_sum[47:0];
	assign sq_try = root_q + bit_q;
	assign dsr    = (root_q[31:0] == '0) ? 32'd1 : root_q[31:0];
	assign dv_try = {rem_q, dvd_q[63]};
	assign t2_now = {prod_q[40:0], 24'd0} + {1'b0, lo_q};
	assign avg_sum = 65'(prod_q) + (r_q[47] ? -65'(signed'(t2_q)) : 65'(signed'(t2_q)));
	assign avg_rnd = (avg_sum + 65'sd32768) >>> 16;
	assign w_sum  = 49'(w_rd_q) + delta_q;

	assign quo_fin = {quo_q[62:0], (dv_try >= {1'b0, dsr})};
	assign q_clamp = (quo_fin > (64'd1 << 40)) ? (64'd1 << 40) : quo_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			rate_q <= RATE_RESET;
			beta_q <= BETA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[1:0];
				REG_RATE: rate_q <= cfg_data;
				REG_BETA: beta_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			w_mem[clr_q] <= '0;
			h_mem[clr_q] <= '0;
		end else if (state_q == S_WB) begin
			w_mem[idx_q] <= wnew_q;
			if (h_we_q) h_mem[idx_q] <= hnew_q;
		end
		if (accept) begin
			w_rd_q <= w_mem[grad.weight_index];
			h_rd_q <= h_mem[grad.weight_index];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p[63:0];
		case (state_q)
			S_IDLE: begin
				idx_q  <= grad.weight_index;
				cmd_q  <= grad.cmd;
				val_q  <= grad.data_value;
				flag_q <= 1'b0;
				h_we_q <= 1'b0;
			end
			S_RV: begin
				wnew_q <= (cmd_q == CMD_LOAD) ? val_q : w_rd_q;
			end
			S_MODE: begin
				rv_q <= prod_q;
				r_q  <= r_now;
				delta_q <= (mode_q == MODE_MOMENTUM && avg_q == '0) ? 49'(val_q) : 49'(r_now);
			end
			S_HIST: begin
				hnew_q <= h_sat;
				h_we_q <= 1'b1;
				if (h_sum[48]) flag_q <= 1'b1;
				op_q   <= {h_sat, 16'd0};
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
				cnt_q  <= '0;
			end
			S_SQRT: begin
				if (op_q >= sq_try) begin
					op_q   <= op_q - sq_try;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == 6'd31) begin
					dvd_q <= rv_q[63] ? 64'(-rv_q) : 64'(rv_q);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			S_DIV: begin
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 6'd1;
				if (dv_try >= {1'b0, dsr}) begin
					rem_q <= 32'(dv_try - {1'b0, dsr});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= dv_try[31:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				if (cnt_q == 6'd63)
					delta_q <= rv_q[63] ? -49'(q_clamp[40:0]) : 49'(q_clamp[40:0]);
			end
			S_CHI: lo_q <= 64'(prod_q);
			S_CB:  t2_q <= t2_now;
			S_AVG: begin
				if (t2_q > (65'd1 << 62)) begin
					flag_q  <= 1'b1;
					delta_q <= r_q[47] ? -49'sd2147483648 : 49'sd2147483647;
				end else begin
					delta_q <= 49'(sat32(avg_rnd[48:0]));
					if (avg_rnd > 65'sd2147483647 || avg_rnd < -65'sd2147483648)
						flag_q <= 1'b1;
				end
			end
			S_ADD: begin
				wnew_q <= sat32(w_sum);
				if (ovf32(w_sum)) flag_q <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			avg_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && !res_stall && state_q != S_WB) res_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(WEIGHT_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (accept) state_q <= S_RV;
				S_RV: state_q <= (cmd_q == CMD_APPLY) ? S_MODE : S_WB;
				S_MODE: begin
					if (mode_q == MODE_MOMENTUM && avg_q == '0) avg_q <= val_q;
					case (mode_q)
						MODE_ADAGRAD:  state_q <= S_HIST;
						MODE_MOMENTUM: state_q <= (avg_q == '0) ? S_ADD : S_CLO;
						default:       state_q <= S_ADD;
					endcase
				end
				S_HIST: state_q <= S_SQRT;
				S_SQRT: if (cnt_q == 6'd31) state_q <= S_DIV;
				S_DIV: if (cnt_q == 6'd63) state_q <= S_ADD;
				S_CLO: state_q <= S_CHI;
				S_CHI: state_q <= S_CB;
				S_CB:  state_q <= S_AVG;
				S_AVG: begin
					if (t2_q > (65'd1 << 62))
						avg_q <= r_q[47] ? 32'sh80000000 : 32'sh7FFFFFFF;
					else
						avg_q <= sat32(avg_rnd[48:0]);
					state_q <= S_ADD;
				end
				S_ADD: state_q <= S_WB;
				S_WB: begin
					if (out_free) begin
						res_valid         <= 1'b1;
						res.out_index     <= idx_q;
						res.weight_out    <= wnew_q;
						res.saturated     <= flag_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
